@@ rtl/spd_pkg.sv @@
// ============================================================================
// spd_pkg
// Shared constants for the stream peak detector and its channel interfaces.
// ============================================================================
`default_nettype none

package spd_pkg;

  // Default field widths
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int INDEX_WIDTH_DEF  = 16;

  // Result queue sizing: one item may push two results, so keep room for two
  // pushes beyond the entry being drained.
  localparam int RESULT_QUEUE_DEPTH = 4;
  localparam int RESULT_QUEUE_IDX_W = $clog2(RESULT_QUEUE_DEPTH);
  localparam int RESULT_QUEUE_CNT_W = $clog2(RESULT_QUEUE_DEPTH + 1);

endpackage

`default_nettype wire

@@ rtl/spd_if.sv @@
// ============================================================================
// spd_if
// Valid/ready channel interfaces for the sample input and the peak results.
// ============================================================================
`default_nettype none

interface spd_in_if #(
  parameter int SAMPLE_WIDTH = spd_pkg::SAMPLE_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;
  logic                           final_sample;

  modport source (output valid, output sample, output final_sample, input ready);
  modport sink   (input valid, input sample, input final_sample, output ready);
endinterface

interface spd_out_if #(
  parameter int SAMPLE_WIDTH = spd_pkg::SAMPLE_WIDTH_DEF,
  parameter int INDEX_WIDTH  = spd_pkg::INDEX_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] peak_value;
  logic        [INDEX_WIDTH-1:0]  peak_position;
  logic                           run_end;

  modport source (output valid, output peak_value, output peak_position,
                  output run_end, input ready);
  modport sink   (input valid, input peak_value, input peak_position,
                  input run_end, output ready);
endinterface

`default_nettype wire

@@ rtl/stream_peak_detector.sv @@
// ============================================================================
// stream_peak_detector
// Streaming local-maximum detector: reports peak value and position per run.
// ============================================================================
// Results: each result enters the registered result queue and is presented
//   on out_if once the entries ahead of it are taken; a second result of the same item follows it.
// Throughput: one input transaction per cycle while the four-entry result
//   queue holds at most two entries; it drains one result per cycle while out_if.ready is high.
// Reset: synchronous active-low rst_n empties the queue and returns the
//   detector to the start of a new sequence.
`default_nettype none

module stream_peak_detector #(
  parameter int SAMPLE_WIDTH = spd_pkg::SAMPLE_WIDTH_DEF,
  parameter int INDEX_WIDTH  = spd_pkg::INDEX_WIDTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  spd_in_if.sink     in_if,
  spd_out_if.source  out_if
);

  localparam int QD   = spd_pkg::RESULT_QUEUE_DEPTH;
  localparam int QI_W = spd_pkg::RESULT_QUEUE_IDX_W;
  localparam int QC_W = spd_pkg::RESULT_QUEUE_CNT_W;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] value;
    logic        [INDEX_WIDTH-1:0]  position;
    logic                           run_end;
  } result_t;

  // --------------------------------------------------------------------------
  // Detector state: the two most recent samples and the saturating index.
  // --------------------------------------------------------------------------
  logic signed [SAMPLE_WIDTH-1:0] older_r,    older_nxt;
  logic signed [SAMPLE_WIDTH-1:0] middle_r,   middle_nxt;
  logic        [INDEX_WIDTH-1:0]  count_r,    count_nxt;
  logic                           have_two_r, have_two_nxt;

  // Result queue: fixed-position slots, head at slot 0.
  result_t         q_r [QD];
  result_t         q_nxt [QD];
  logic [QC_W-1:0] qcnt_r, qcnt_nxt;

  logic                           in_fire;
  logic                           out_fire;
  logic signed [SAMPLE_WIDTH-1:0] x;
  logic                           count_zero;
  logic                           count_max;
  logic        [INDEX_WIDTH-1:0]  mid_pos;
  logic                           mid_peak;
  logic                           fin_peak;
  result_t                        res_mid;
  result_t                        res_fin;

  // Accept while two slots are free, so a two-result item always fits.
  assign in_if.ready  = (qcnt_r <= QC_W'(QD - 2));
  assign in_fire      = in_if.valid && in_if.ready;
  assign out_if.valid = (qcnt_r != '0);
  assign out_fire     = out_if.valid && out_if.ready;

  assign out_if.peak_value    = q_r[0].value;
  assign out_if.peak_position = q_r[0].position;
  assign out_if.run_end       = q_r[0].run_end;

  // --------------------------------------------------------------------------
  // Peak decisions for the accepted transaction
  // --------------------------------------------------------------------------
  assign x          = in_if.sample;
  assign count_zero = (count_r == '0);
  assign count_max  = (count_r == '1);

  // Middle sample sits one behind the new one, unless the index has saturated.
  assign mid_pos = count_max ? {{(INDEX_WIDTH-1){1'b1}}, 1'b0}
                             : INDEX_WIDTH'(count_r - 1'b1);

  // First sample has no predecessor: judge it against its successor only.
  assign mid_peak = !count_zero &&
                    (have_two_r ? ((middle_r > older_r) && (middle_r >= x))
                                : (middle_r > x));
  assign fin_peak = !count_zero && in_if.final_sample && (x > middle_r);

  always_comb begin
    res_mid.value    = middle_r;
    res_mid.position = mid_pos;
    res_mid.run_end  = !fin_peak;
    res_fin.value    = x;
    res_fin.position = count_r;
    res_fin.run_end  = 1'b1;
  end

  // --------------------------------------------------------------------------
  // State update: the final sample returns the detector to its reset state.
  // --------------------------------------------------------------------------
  always_comb begin
    older_nxt    = older_r;
    middle_nxt   = middle_r;
    count_nxt    = count_r;
    have_two_nxt = have_two_r;
    if (in_fire) begin
      if (in_if.final_sample) begin
        older_nxt    = '0;
        middle_nxt   = '0;
        count_nxt    = '0;
        have_two_nxt = 1'b0;
      end else begin
        older_nxt    = middle_r;
        middle_nxt   = x;
        count_nxt    = count_max ? count_r : INDEX_WIDTH'(count_r + 1'b1);
        have_two_nxt = !count_zero;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result queue: pop at the head, then append the middle result and the
  // final-sample result in that order.
  // --------------------------------------------------------------------------
  always_comb begin
    logic [QC_W-1:0] cnt;
    cnt = qcnt_r;
    for (int i = 0; i < QD; i++) begin
      q_nxt[i] = q_r[i];
    end
    if (out_fire) begin
      for (int i = 0; i < QD - 1; i++) begin
        q_nxt[i] = q_r[i + 1];
      end
      cnt = QC_W'(cnt - 1'b1);
    end
    if (in_fire && mid_peak) begin
      q_nxt[cnt[QI_W-1:0]] = res_mid;
      cnt = QC_W'(cnt + 1'b1);
    end
    if (in_fire && fin_peak) begin
      q_nxt[cnt[QI_W-1:0]] = res_fin;
      cnt = QC_W'(cnt + 1'b1);
    end
    qcnt_nxt = cnt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      older_r    <= '0;
      middle_r   <= '0;
      count_r    <= '0;
      have_two_r <= 1'b0;
      qcnt_r     <= '0;
    end else begin
      older_r    <= older_nxt;
      middle_r   <= middle_nxt;
      count_r    <= count_nxt;
      have_two_r <= have_two_nxt;
      qcnt_r     <= qcnt_nxt;
    end
  end

  // Payload slots hold without reset.
  always_ff @(posedge clk) begin
    for (int i = 0; i < QD; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    qcnt_r <= QC_W'(QD))
    else $error("result queue overflow");

  a_two_needs_count: assert property (@(posedge clk) disable iff (!rst_n)
    have_two_r |-> (count_r >= INDEX_WIDTH'(2)))
    else $error("two samples held with index below two");

  a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_if.final_sample) |=> (count_r == '0 && !have_two_r))
    else $error("final sample did not restart the sequence");

  a_first_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && count_zero && !out_fire) |=> (qcnt_r == $past(qcnt_r)))
    else $error("first sample of a sequence produced a result");

endmodule

`default_nettype wire

@@ tb/spd_checker.sv @@
`timescale 1ns / 1ps
// ============================================================================
// spd_checker
// Watches both channels of the stream peak detector, tracks the sequence
// state on its own and compares every peak result with the one it predicts.
// ============================================================================

module spd_checker (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         in_valid,
  input  logic                                         in_ready,
  input  logic signed [spd_pkg::SAMPLE_WIDTH_DEF-1:0]  in_sample,
  input  logic                                         in_final_sample,
  input  logic                                         out_valid,
  input  logic                                         out_ready,
  input  logic signed [spd_pkg::SAMPLE_WIDTH_DEF-1:0]  out_peak_value,
  input  logic        [spd_pkg::INDEX_WIDTH_DEF-1:0]   out_peak_position,
  input  logic                                         out_run_end,
  output int                                           mismatch_count,
  output int                                           peaks_pending,
  output int                                           peaks_checked
);

  localparam int SW = spd_pkg::SAMPLE_WIDTH_DEF;
  localparam int IW = spd_pkg::INDEX_WIDTH_DEF;
  localparam logic [IW-1:0] POSITION_MAX = '1;

  typedef struct {
    logic signed [SW-1:0] value;
    logic        [IW-1:0] position;
    logic                 run_end;
  } peak_t;

  // Sequence state: the two newest samples, how many were seen, and whether
  // the older one is valid yet.
  logic signed [SW-1:0] older_value;
  logic signed [SW-1:0] middle_value;
  logic        [IW-1:0] seen_count;
  logic                 older_valid;

  peak_t peaks_due[$];

  initial begin
    mismatch_count = 0;
    peaks_checked  = 0;
    peaks_pending  = 0;
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] peak mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  task automatic restart_sequence();
    older_value  = '0;
    middle_value = '0;
    seen_count   = '0;
    older_valid  = 1'b0;
  endtask

  // Judge the held middle sample now that its successor is known, and the
  // new sample too when it closes the sequence.
  task automatic detect_peaks(input logic signed [SW-1:0] x, input logic last);
    peak_t         found[2];
    int            n;
    logic [IW-1:0] new_pos;
    logic [IW-1:0] mid_pos;
    n       = 0;
    new_pos = seen_count;
    mid_pos = (seen_count == POSITION_MAX) ? POSITION_MAX - 1'b1 : seen_count - 1'b1;

    if (seen_count == '0) begin
      // a lone final sample reports nothing and leaves the state at reset
      if (last) begin
        restart_sequence();
      end else begin
        middle_value = x;
        seen_count   = IW'(1);
      end
      return;
    end

    if (!older_valid) begin
      if (middle_value > x) begin
        found[n] = '{value: middle_value, position: '0, run_end: 1'b0};
        n++;
      end
    end else if (middle_value > older_value && middle_value >= x) begin
      found[n] = '{value: middle_value, position: mid_pos, run_end: 1'b0};
      n++;
    end

    if (last && x > middle_value) begin
      found[n] = '{value: x, position: new_pos, run_end: 1'b0};
      n++;
    end
    if (n > 0) found[n-1].run_end = 1'b1;
    for (int k = 0; k < n; k++) peaks_due.insert(peaks_due.size(), found[k]);

    if (last) begin
      restart_sequence();
    end else begin
      older_value  = middle_value;
      middle_value = x;
      older_valid  = 1'b1;
      if (seen_count != POSITION_MAX) seen_count = seen_count + 1'b1;
    end
  endtask

  task automatic check_peak();
    peak_t want;
    if (peaks_due.size() == 0) begin
      report_mismatch($sformatf("unexpected result value %0d position %0d run_end %0b",
                                out_peak_value, out_peak_position, out_run_end));
      return;
    end
    want = peaks_due.pop_front();
    peaks_checked++;
    if (out_peak_value !== want.value)
      report_mismatch($sformatf("peak_value %0d, want %0d (position %0d)",
                                out_peak_value, want.value, want.position));
    if (out_peak_position !== want.position)
      report_mismatch($sformatf("peak_position %0d, want %0d",
                                out_peak_position, want.position));
    if (out_run_end !== want.run_end)
      report_mismatch($sformatf("run_end %0b, want %0b (position %0d)",
                                out_run_end, want.run_end, want.position));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      restart_sequence();
      peaks_due.delete();
    end else begin
      if (in_valid && in_ready) detect_peaks(in_sample, in_final_sample);
      if (out_valid && out_ready) check_peak();
    end
    peaks_pending <= peaks_due.size();
  end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Drives sample sequences into the stream peak detector under random idling
// and back-pressure, and lets spd_checker judge every peak it reports.
// ============================================================================

module testbench;

  localparam int SW             = spd_pkg::SAMPLE_WIDTH_DEF;
  localparam int RESET_CYCLES   = 10;
  localparam int HOLD_CYCLES    = 300;   // long receiver stall
  localparam int DRAIN_CYCLES   = 10;    // settle time after the last result
  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  // Value patterns for one sequence
  typedef enum int {
    STYLE_WIDE,     // any 16-bit value
    STYLE_NARROW,   // -3..3, dense with ties and peaks
    STYLE_EXTREME,  // corners of the signed range
    STYLE_WALK      // small steps from the previous sample, wrapping freely
  } run_style_e;

  logic clk;
  logic rst_n;

  spd_in_if  in_ch ();
  spd_out_if out_ch ();

  stream_peak_detector dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  int mismatch_count;
  int peaks_pending;
  int peaks_checked;

  spd_checker checker_i (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_ch.valid),
    .in_ready          (in_ch.ready),
    .in_sample         (in_ch.sample),
    .in_final_sample   (in_ch.final_sample),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_peak_value    (out_ch.peak_value),
    .out_peak_position (out_ch.peak_position),
    .out_run_end       (out_ch.run_end),
    .mismatch_count    (mismatch_count),
    .peaks_pending     (peaks_pending),
    .peaks_checked     (peaks_checked)
  );

  // Idling controls shared by the sender and the receiver process
  bit sender_eager;     // no gaps between input transactions
  bit receiver_eager;   // no stalls before result transactions
  bit hold_results;     // ask the receiver for one long stall

  int samples_sent;
  int runs_sent;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Guard against a hung handshake.
  int unsigned cycle_count;
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d peaks outstanding",
               cycle_count, peaks_pending);
      $display("TEST FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Result receiver: insert a random stall before each result transaction, or
  // not at all in eager stretches. On request, hold ready low for a long
  // stretch so the result queue fills and the detector stalls its input.
  // --------------------------------------------------------------------------
  initial begin : result_receiver
    int stall;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_results) begin
        hold_results = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      stall = receiver_eager ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      // ready is high at every edge here, so valid alone marks the transaction
      do @(posedge clk); while (out_ch.valid !== 1'b1);
    end
  end

  // --------------------------------------------------------------------------
  // Sender helpers
  // --------------------------------------------------------------------------

  // Offer one sample after a random gap and hold it until accepted. Valid
  // stays high on return so a back-to-back sample needs no extra edge.
  task automatic send_sample(input logic signed [SW-1:0] value, input logic last);
    int gap;
    gap = sender_eager ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.sample       <= value;
    in_ch.final_sample <= last;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    samples_sent++;
  endtask

  // Drop valid and wait until every predicted peak has come out.
  task automatic wait_for_peaks();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (peaks_pending != 0);
  endtask

  // Send a fixed sequence; the last entry carries the final flag.
  task automatic send_fixed_run(input int values[$]);
    foreach (values[i]) send_sample(SW'(values[i]), i == values.size() - 1);
    runs_sent++;
  endtask

  function automatic logic signed [SW-1:0] pick_sample(input run_style_e style,
                                                        input logic signed [SW-1:0] prev);
    case (style)
      STYLE_WIDE:   return SW'($urandom);
      STYLE_NARROW: return SW'($urandom_range(0, 6)) - SW'(3);
      STYLE_EXTREME: begin
        case ($urandom_range(0, 5))
          0:       return {1'b1, {(SW-1){1'b0}}};
          1:       return {1'b0, {(SW-1){1'b1}}};
          2:       return {1'b1, {(SW-2){1'b0}}, 1'b1};
          3:       return '1;
          4:       return '0;
          default: return SW'(1);
        endcase
      end
      default:      return prev + SW'($urandom_range(0, 8)) - SW'(4);
    endcase
  endfunction

  // Send whole random sequences until at least item_goal samples went out.
  task automatic send_random_runs(input int item_goal, input bit narrow_only);
    int                   sent;
    int                   run_len;
    run_style_e           style;
    logic signed [SW-1:0] value;
    sent = 0;
    while (sent < item_goal) begin
      case ($urandom_range(0, 9))
        0:       run_len = 1;
        1:       run_len = 2;
        default: run_len = $urandom_range(3, 40);
      endcase
      style = narrow_only ? STYLE_NARROW : run_style_e'($urandom_range(0, 3));
      value = SW'($urandom);
      for (int i = 0; i < run_len; i++) begin
        value = pick_sample(style, value);
        send_sample(value, i == run_len - 1);
      end
      sent += run_len;
      runs_sent++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus and verdict
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int run_values[$];
    sender_eager   = 1'b0;
    receiver_eager = 1'b0;
    hold_results   = 1'b0;
    samples_sent   = 0;
    runs_sent      = 0;
    in_ch.valid        <= 1'b0;
    in_ch.sample       <= '0;
    in_ch.final_sample <= 1'b0;
    rst_n              <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: a lone final sample gives nothing
    run_values = {5};
    send_fixed_run(run_values);
    // first sample at full scale above the minimum, final rising again
    run_values = {32767, -32768, 0};
    send_fixed_run(run_values);
    // two-sample sequences: rising, falling, flat
    run_values = {1, 2};
    send_fixed_run(run_values);
    run_values = {2, 1};
    send_fixed_run(run_values);
    run_values = {3, 3};
    send_fixed_run(run_values);
    // interior peak tied with its successor; the tied follower is no peak
    run_values = {0, 5, 5, 1};
    send_fixed_run(run_values);
    // bottom of the range, first sample just above the minimum
    run_values = {-32767, -32768, -32768};
    send_fixed_run(run_values);
    // plateau: only its first sample counts
    run_values = {1, 5, 5, 5, 2};
    send_fixed_run(run_values);
    wait_for_peaks();

    // Random sequences with idling on both sides
    send_random_runs(400, 1'b0);

    // Stall the results for a long stretch while samples keep coming
    sender_eager = 1'b1;
    hold_results = 1'b1;
    send_random_runs(150, 1'b1);

    // A stretch with no idling at all
    receiver_eager = 1'b1;
    send_random_runs(200, 1'b0);

    // Pause the sender until every peak is out, then resume with idling
    sender_eager   = 1'b0;
    receiver_eager = 1'b0;
    wait_for_peaks();
    send_random_runs(250, 1'b0);
    wait_for_peaks();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d samples in %0d sequences, %0d peaks checked",
             samples_sent, runs_sent, peaks_checked);
    $display("Idling, a %0d-cycle result stall and a drained pause were included",
             HOLD_CYCLES);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
